// File: rtl/core/ecg_ogc_pkg.sv
// Shared types and constants of the ECG offset/gain AGC unit.
package ecg_ogc_pkg;

    // baseline tracking shifts
    localparam int BASE_FAST_SHIFT = 9;
    localparam int BASE_SLOW_SHIFT = 14;

    // amplitude tracker value after reset
    localparam int TRACKER_RESET = 4194304;

    // chart scaling is x128, done as a shift
    localparam int CHART_SCALE_SHIFT = 7;
    localparam int CHART_POS_LIMIT   = 127;
    localparam int CHART_NEG_LIMIT   = 128;
    localparam logic signed [7:0] CHART_MAX = 8'sd127;
    localparam logic signed [7:0] CHART_MIN = -8'sd128;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 25;

    // front-to-back queue depth, power of two
    localparam int QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [23:0] DRIFT_LIMIT_RST     = 24'd200;
    localparam logic [24:0] AMP_THRESH_RST      = 25'd1200000;
    localparam logic [23:0] DIV_BIAS_RST        = 24'd1500000;
    localparam logic [4:0]  RISE_FAST_SHIFT_RST = 5'd5;
    localparam logic [4:0]  RISE_SLOW_SHIFT_RST = 5'd7;
    localparam logic [4:0]  FALL_FAST_SHIFT_RST = 5'd12;
    localparam logic [4:0]  FALL_SLOW_SHIFT_RST = 5'd13;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DRIFT_LIMIT     = 3'd0,
        CFG_AMP_THRESH      = 3'd1,
        CFG_DIV_BIAS        = 3'd2,
        CFG_RISE_FAST_SHIFT = 3'd3,
        CFG_RISE_SLOW_SHIFT = 3'd4,
        CFG_FALL_FAST_SHIFT = 3'd5,
        CFG_FALL_SLOW_SHIFT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] drift_limit;
        logic [24:0] amp_thresh;
        logic [23:0] div_bias;
        logic [4:0]  rise_fast_shift;
        logic [4:0]  rise_slow_shift;
        logic [4:0]  fall_fast_shift;
        logic [4:0]  fall_slow_shift;
    } t_cfg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ERR,
        F_BASE,
        F_REM,
        F_GERR,
        F_AMP,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_back_state;

endpackage

// File: rtl/core/ecg_ogc_ifs.sv
// Stream interfaces for the sample input and chart value output channels.
interface ecg_ogc_sample_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ecg_ogc_chart_if ();
    logic              valid;
    logic              ready;
    logic signed [7:0] chart_value;

    modport source (output valid, output chart_value, input ready);
    modport sink   (input valid, input chart_value, output ready);
endinterface

// File: rtl/core/ecg_offset_gain_agc_unit.sv
// Top level of the ECG baseline removal and gain control unit.
//
//  channel   dir  modport  payload                       word accepted when
//  i_smp     in   sink     sample      [SAMPLE_BITS] s   valid && ready
//  o_chart   out  source   chart_value [8] s             valid && ready
//  i_cfg_*   in   -        idx [3], data [25]            i_cfg_we high
//
// The front takes a sample, then runs six tracking steps; a full queue holds the last one.
// The back divides one bit per cycle, SAMPLE_BITS + 7 quotient bits per word;
// that restoring divider sets the sustained rate.
// A two-word queue sits between front and back; the output register lets the
// divider start the next word while a chart value waits to be taken.
// Synchronous reset restores tracker, baseline and registers; no clearing pass.
module ecg_offset_gain_agc_unit
    import ecg_ogc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ecg_ogc_sample_if.sink           i_smp,
    ecg_ogc_chart_if.source          o_chart,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int BW = SAMPLE_BITS + 1;
    localparam int TW = (SAMPLE_BITS + 1 > 23) ? SAMPLE_BITS + 1 : 23;
    localparam int DW = ((TW > 24) ? TW : 24) + 1;
    localparam int QW = BW + DW;

    t_cfg          r_cfg;
    logic          q_push_valid;
    logic          q_push_ready;
    logic [QW-1:0] q_push_data;
    logic          q_pop_valid;
    logic          q_pop_ready;
    logic [QW-1:0] q_pop_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drift_limit     <= DRIFT_LIMIT_RST;
            r_cfg.amp_thresh      <= AMP_THRESH_RST;
            r_cfg.div_bias        <= DIV_BIAS_RST;
            r_cfg.rise_fast_shift <= RISE_FAST_SHIFT_RST;
            r_cfg.rise_slow_shift <= RISE_SLOW_SHIFT_RST;
            r_cfg.fall_fast_shift <= FALL_FAST_SHIFT_RST;
            r_cfg.fall_slow_shift <= FALL_SLOW_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DRIFT_LIMIT:     r_cfg.drift_limit     <= i_cfg_data[23:0];
                CFG_AMP_THRESH:      r_cfg.amp_thresh      <= i_cfg_data[24:0];
                CFG_DIV_BIAS:        r_cfg.div_bias        <= i_cfg_data[23:0];
                CFG_RISE_FAST_SHIFT: r_cfg.rise_fast_shift <= i_cfg_data[4:0];
                CFG_RISE_SLOW_SHIFT: r_cfg.rise_slow_shift <= i_cfg_data[4:0];
                CFG_FALL_FAST_SHIFT: r_cfg.fall_fast_shift <= i_cfg_data[4:0];
                CFG_FALL_SLOW_SHIFT: r_cfg.fall_slow_shift <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    ecg_ogc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_smp        (i_smp),
        .o_push_valid (q_push_valid),
        .i_push_ready (q_push_ready),
        .o_push_data  (q_push_data)
    );

    ecg_ogc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push_data  (q_push_data),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_data   (q_pop_data)
    );

    ecg_ogc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .o_pop_ready (q_pop_ready),
        .i_pop_data  (q_pop_data),
        .o_chart     (o_chart)
    );

    // reset empties the output register
    a_out_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_chart.valid)
        else $error("chart output valid after reset");

    // front is busy for the tracking steps after taking a sample
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("front took a sample while tracking");

    // a word stalled at the queue stays put
    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push_valid && !q_push_ready) |=> (q_push_valid && $stable(q_push_data)))
        else $error("queue word changed while stalled");

    // divider does not pop again while it works
    a_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop_valid && q_pop_ready) |=> !q_pop_ready)
        else $error("divider popped while busy");

endmodule

// File: rtl/core/ecg_ogc_queue.sv
// Small register FIFO between the tracking front and the divider back.
module ecg_ogc_queue
    import ecg_ogc_pkg::*;
#(
    parameter int WIDTH = 58
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (PW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push_data;
    end

endmodule

// File: rtl/core/ecg_ogc_front.sv
// Front end: accepts samples, updates baseline and amplitude tracker, forms divisor.
module ecg_ogc_front
    import ecg_ogc_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    localparam int BW = SAMPLE_BITS + 1,
    localparam int TW = (SAMPLE_BITS + 1 > 23) ? SAMPLE_BITS + 1 : 23,
    localparam int DW = ((TW > 24) ? TW : 24) + 1,
    localparam int QW = BW + DW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    ecg_ogc_sample_if.sink         i_smp,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output logic [QW-1:0]          o_push_data
);
    localparam int EW = SAMPLE_BITS + 2;
    localparam int GW = TW + 1;
    localparam int CW = (GW > 25) ? GW : 25;

    t_front_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [BW-1:0]          r_baseline;
    logic        [TW-1:0]          r_tracker;
    logic signed [EW-1:0]          r_err;
    logic signed [BW-1:0]          r_removed;
    logic signed [GW-1:0]          r_gerr;

    logic signed [EW-1:0] err_c;
    logic        [EW-1:0] mag_err;
    logic                 base_small;
    logic signed [EW-1:0] base_step;
    logic signed [BW-1:0] base_next;
    logic signed [BW-1:0] removed_c;
    logic        [BW-1:0] rem_mag;
    logic signed [GW-1:0] gerr_c;
    logic                 amp_pos;
    logic        [TW-1:0] amp_mag;
    logic                 amp_small;
    logic        [4:0]    amp_shift;
    logic        [TW-1:0] amp_delta;
    logic        [TW-1:0] trk_next;
    logic        [DW-1:0] den_c;

    // baseline error and step: slow shift for small errors
    assign err_c      = EW'(r_sample) - EW'(r_baseline);
    assign mag_err    = r_err[EW-1] ? EW'(-r_err) : EW'(r_err);
    assign base_small = CW'(mag_err) < CW'(i_cfg.drift_limit);
    assign base_step  = base_small ? (r_err >>> BASE_SLOW_SHIFT)
                                   : (r_err >>> BASE_FAST_SHIFT);
    assign base_next  = BW'(EW'(r_baseline) + base_step);

    // baseline-removed sample and amplitude error
    assign removed_c = BW'(EW'(r_sample) - EW'(r_baseline));
    assign rem_mag   = r_removed[BW-1] ? BW'(-r_removed) : BW'(r_removed);
    assign gerr_c    = $signed(GW'(rem_mag)) - $signed(GW'(r_tracker));

    // tracker rise/fall with threshold-selected shift
    assign amp_pos   = !r_gerr[GW-1];
    assign amp_mag   = TW'(r_gerr[GW-1] ? -r_gerr : r_gerr);
    assign amp_small = CW'(amp_mag) < CW'(i_cfg.amp_thresh);
    always_comb begin
        if (amp_pos) begin
            amp_shift = amp_small ? i_cfg.rise_slow_shift : i_cfg.rise_fast_shift;
        end else begin
            amp_shift = amp_small ? i_cfg.fall_slow_shift : i_cfg.fall_fast_shift;
        end
    end
    assign amp_delta = amp_mag >> amp_shift;
    assign trk_next  = amp_pos ? (r_tracker + amp_delta) : (r_tracker - amp_delta);

    // divisor from the updated tracker
    assign den_c = DW'(r_tracker) + DW'(i_cfg.div_bias);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_smp.valid) n_state = F_ERR;
            end
            F_ERR:  n_state = F_BASE;
            F_BASE: n_state = F_REM;
            F_REM:  n_state = F_GERR;
            F_GERR: n_state = F_AMP;
            F_AMP:  n_state = F_PUSH;
            F_PUSH: begin
                if (i_push_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_smp.ready  = 1'b0;
        o_push_valid = 1'b0;
        case (r_state)
            F_IDLE:  i_smp.ready  = 1'b1;
            F_PUSH:  o_push_valid = 1'b1;
            default: begin
                i_smp.ready  = 1'b0;
                o_push_valid = 1'b0;
            end
        endcase
    end

    assign o_push_data = {r_removed, den_c};

    // state and tracking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_baseline <= '0;
            r_tracker  <= TW'(TRACKER_RESET);
        end else begin
            r_state <= n_state;
            case (r_state)
                F_BASE:  r_baseline <= base_next;
                F_AMP:   r_tracker  <= trk_next;
                default: ;
            endcase
        end
    end

    // per-word working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE:  r_sample  <= i_smp.sample;
            F_ERR:   r_err     <= err_c;
            F_REM:   r_removed <= removed_c;
            F_GERR:  r_gerr    <= gerr_c;
            default: ;
        endcase
    end

endmodule

// File: rtl/core/ecg_ogc_back.sv
// Back end: restoring divider, chart saturation and output register.
module ecg_ogc_back
    import ecg_ogc_pkg::*;
#(
    parameter  int SAMPLE_BITS = 24,
    localparam int BW = SAMPLE_BITS + 1,
    localparam int TW = (SAMPLE_BITS + 1 > 23) ? SAMPLE_BITS + 1 : 23,
    localparam int DW = ((TW > 24) ? TW : 24) + 1,
    localparam int QW = BW + DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  logic [QW-1:0] i_pop_data,
    ecg_ogc_chart_if.source o_chart
);
    localparam int NW   = SAMPLE_BITS + CHART_SCALE_SHIFT;
    localparam int CNTW = $clog2(NW);

    t_back_state r_state, n_state;

    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic            r_neg;
    logic            r_zero;
    logic [CNTW-1:0] r_cnt;
    logic signed [7:0] r_chart;
    logic            r_out_valid;

    logic signed [BW-1:0] rem_in;
    logic        [BW-1:0] mag_in;
    logic        [DW:0]   rem_sh;
    logic                 q_bit;
    logic        [DW:0]   rem_sub;
    logic signed [7:0]    chart_c;
    logic                 pop;
    logic                 load_out;

    assign rem_in = $signed(i_pop_data[QW-1:DW]);
    assign mag_in = rem_in[BW-1] ? BW'(-rem_in) : BW'(rem_in);

    // one quotient bit per cycle
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    // sign, truncation toward zero and saturation
    always_comb begin
        if (r_zero) begin
            chart_c = '0;
        end else if (!r_neg) begin
            chart_c = (r_num > NW'(CHART_POS_LIMIT)) ? CHART_MAX : $signed(r_num[7:0]);
        end else begin
            chart_c = (r_num > NW'(CHART_NEG_LIMIT)) ? CHART_MIN
                                                     : $signed(8'd0 - r_num[7:0]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_pop_valid) n_state = B_DIV;
            end
            B_DIV: begin
                if (r_cnt == '0) n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_out_valid || o_chart.ready) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop_ready = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            B_IDLE:  o_pop_ready = 1'b1;
            B_DONE:  load_out    = !r_out_valid || o_chart.ready;
            default: begin
                o_pop_ready = 1'b0;
                load_out    = 1'b0;
            end
        endcase
    end

    assign pop = i_pop_valid && o_pop_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)           r_out_valid <= 1'b1;
            else if (o_chart.ready) r_out_valid <= 1'b0;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_num  <= {mag_in[SAMPLE_BITS-1:0], {CHART_SCALE_SHIFT{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_pop_data[DW-1:0];
            r_neg  <= rem_in[BW-1];
            r_zero <= (rem_in == '0);
            r_cnt  <= CNTW'(NW - 1);
        end else if (r_state == B_DIV) begin
            r_num <= {r_num[NW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (load_out) r_chart <= chart_c;
    end

    assign o_chart.valid       = r_out_valid;
    assign o_chart.chart_value = r_chart;

endmodule
